// ----- src/sps_pkg.sv -----
package sps_pkg;

    localparam int CHANNELS     = 7;
    localparam int PIN_BITS     = 7;
    localparam int FIRST_START  = 532;
    localparam int SLOT_SPACING = 2782;
    localparam int BUFFER_BYTES = 16;
    localparam int INDEX_BITS   = $clog2(BUFFER_BYTES + 1);
    localparam int ADDR_BITS    = $clog2(BUFFER_BYTES);
    localparam int TARGET_POS   = 14;

    localparam logic [15:0] FRAME_TOP_RESET = 16'd19999;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_START  = 2'd1;
    localparam logic [1:0] ACT_BYTE   = 2'd2;
    localparam logic [1:0] ACT_EDGE   = 2'd3;

    typedef logic [15:0] width_arr_t [PIN_BITS];
    typedef logic [7:0]  byte_arr_t [BUFFER_BYTES];

    localparam width_arr_t WIDTH_RESET = '{
        16'd630, 16'd1000, 16'd1500, 16'd1750, 16'd2000, 16'd2250, 16'd2100
    };

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [PIN_BITS-1:0] channel_pins;
        logic                target_reached;
        logic [15:0]         encoder_count;
    } out_t;

    function automatic logic [16:0] start_tick(input int idx);
        start_tick = 17'(FIRST_START + idx * SLOT_SPACING);
    endfunction

endpackage

// ----- src/sps_pins.sv -----
module sps_pins
(
    input  logic [15:0]                  frame_count,
    input  sps_pkg::width_arr_t          widths,
    output logic [sps_pkg::PIN_BITS-1:0] pins
);

    for (genvar i = 0; i < sps_pkg::PIN_BITS; i++)
    begin : g_chan
        if (i < sps_pkg::CHANNELS)
        begin : g_used
            localparam logic [16:0] START = sps_pkg::start_tick(i);
            localparam logic [15:0] SLOT  = 16'(sps_pkg::SLOT_SPACING);
            logic [15:0] clamp;
            logic [16:0] offset;
            logic        past_start;

            // Clamp the width to the slot so only one channel is high at once.
            assign clamp      = (widths[i] > SLOT) ? SLOT : widths[i];
            assign past_start = ({1'b0, frame_count} >= START);
            assign offset     = {1'b0, frame_count} - START;
            assign pins[i]    = past_start && (offset[15:0] < clamp);
        end
        else
        begin : g_unused
            assign pins[i] = 1'b0;
        end
    end

endmodule

// ----- src/servo_pulse_sequencer_with_encoder.sv -----
// Channel  | Handshake                  | Payload
// ---------+----------------------------+--------------------------------------
// in       | in_valid / in_ready        | in_data  (action, data_byte)
// out      | out_valid / out_ready      | out_data (channel_pins, target_reached,
//          |                            |           encoder_count)
// cfg      | cfg_we (no wait)           | cfg_data (frame_top)
//
// One transaction in, one transaction out; the result is registered, valid the
// cycle after acceptance. The event update and pin decode settle between the
// state and result registers, so a transaction is taken each cycle in_ready is
// high; it drops only while a result waits and out_ready is low. rst_n resets
// all state but out_data asynchronously; no clearing pass is needed.
module servo_pulse_sequencer_with_encoder
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sps_pkg::in_t    in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output sps_pkg::out_t   out_data,
    input  logic            cfg_we,
    input  logic [15:0]     cfg_data
);

    localparam int NB = sps_pkg::BUFFER_BYTES;

    // Architectural state
    logic [15:0]                       frame_top_reg;
    logic [15:0]                       frame_count_reg, frame_count_next;
    sps_pkg::byte_arr_t                rx_buf_reg, rx_buf_next;
    logic [sps_pkg::INDEX_BITS-1:0]    rx_index_reg, rx_index_next;
    // Widths follow the buffer once any byte has arrived; before that they
    // hold their reset table.
    logic                              loaded_reg, loaded_next;
    logic [15:0]                       edge_count_reg, edge_count_next;
    logic                              reached_reg, reached_next;

    // Result register
    logic                              out_valid_reg;
    sps_pkg::out_t                     out_data_reg, out_data_next;

    sps_pkg::width_arr_t               widths_next;
    logic [15:0]                       target_next;
    logic [15:0]                       edge_inc;
    logic [sps_pkg::PIN_BITS-1:0]      pins_next;
    logic                              accept;

    // Take a new transaction whenever the result slot is empty or draining.
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign edge_inc = edge_count_reg + 16'd1;

    always_comb
    begin
        frame_count_next = frame_count_reg;
        rx_buf_next      = rx_buf_reg;
        rx_index_next    = rx_index_reg;
        loaded_next      = loaded_reg;
        edge_count_next  = edge_count_reg;
        reached_next     = reached_reg;

        unique case (in_data.action)
            sps_pkg::ACT_TICK:
            begin
                // Wrap at or past the top so a lowered top takes hold at once.
                if (frame_count_reg >= frame_top_reg)
                    frame_count_next = '0;
                else
                    frame_count_next = frame_count_reg + 16'd1;
            end
            sps_pkg::ACT_START:
            begin
                rx_index_next = '0;
            end
            sps_pkg::ACT_BYTE:
            begin
                loaded_next = 1'b1;
                // Drop bytes once the buffer is full.
                if (rx_index_reg < sps_pkg::INDEX_BITS'(NB))
                begin
                    rx_buf_next[rx_index_reg[sps_pkg::ADDR_BITS-1:0]] = in_data.data_byte;
                    rx_index_next = rx_index_reg + sps_pkg::INDEX_BITS'(1);
                end
            end
            sps_pkg::ACT_EDGE:
            begin
                if (edge_inc == {rx_buf_reg[sps_pkg::TARGET_POS],
                                 rx_buf_reg[sps_pkg::TARGET_POS + 1]})
                begin
                    reached_next    = 1'b1;
                    edge_count_next = '0;
                end
                else
                begin
                    reached_next    = 1'b0;
                    edge_count_next = edge_inc;
                end
            end
            default:
            begin
                frame_count_next = frame_count_reg;
            end
        endcase

        // Target is always the last big-endian pair of the buffer.
        target_next = {rx_buf_next[sps_pkg::TARGET_POS],
                       rx_buf_next[sps_pkg::TARGET_POS + 1]};
        if (in_data.action == sps_pkg::ACT_BYTE && target_next != edge_count_reg)
            reached_next = 1'b0;

        for (int i = 0; i < sps_pkg::PIN_BITS; i++)
        begin
            widths_next[i] = loaded_next ? {rx_buf_next[2*i], rx_buf_next[2*i + 1]}
                                         : sps_pkg::WIDTH_RESET[i];
        end
    end

    sps_pins u_pins
    (
        .frame_count (frame_count_next),
        .widths      (widths_next),
        .pins        (pins_next)
    );

    always_comb
    begin
        out_data_next.channel_pins   = pins_next;
        out_data_next.target_reached = reached_next;
        out_data_next.encoder_count  = edge_count_next;
    end

    // Hold the frame top; the user must write it only while idle, which the block does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_top_reg <= sps_pkg::FRAME_TOP_RESET;
        else if (cfg_we)
            frame_top_reg <= cfg_data;
    end

    // Advance the state on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            rx_buf_reg      <= '{default: '0};
            rx_index_reg    <= '0;
            loaded_reg      <= 1'b0;
            edge_count_reg  <= '0;
            reached_reg     <= 1'b0;
        end
        else if (accept)
        begin
            frame_count_reg <= frame_count_next;
            rx_buf_reg      <= rx_buf_next;
            rx_index_reg    <= rx_index_next;
            loaded_reg      <= loaded_next;
            edge_count_reg  <= edge_count_next;
            reached_reg     <= reached_next;
        end
    end

    // Result slot: load on accept, empty when taken with nothing new behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

endmodule

// ----- verif/tb_servo_pulse_sequencer_with_encoder.sv -----
`timescale 1ns / 100ps

module tb_servo_pulse_sequencer_with_encoder;

    import sps_pkg::*;

    // Cycles without any transaction on either side before the run is abandoned.
    // The longest legal quiet stretch is the forced receiver hold-off plus a long
    // sender gap, so this leaves a wide margin.
    localparam int QUIET_LIMIT    = 5000;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_EVENTS   = 120;
    localparam int SWEEP_TICKS    = 760;
    localparam int SWEEP_SWAP     = 560;
    localparam int EDGE_RUN       = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_t         in_data;
    logic        out_valid;
    logic        out_ready;
    out_t        out_data;
    logic        cfg_we;
    logic [15:0] cfg_data;

    // Shadow copy of the sequencer state, advanced once per accepted input
    // transaction.
    logic [15:0] frame_top_set;
    logic [15:0] frame_tick;
    byte_arr_t   rx_bytes;
    int          rx_fill;
    width_arr_t  pulse_width;
    logic [15:0] edge_total;
    logic [15:0] edge_goal;
    logic        goal_hit;

    out_t        predicted_outputs [$];
    int          mismatches;
    int          quiet_cycles;
    int          events_sent;

    // Random idling is switched on and off per test; a nonzero stall_budget
    // makes the receiver hold off for that many cycles on its next turn.
    bit          idle_on;
    int          stall_budget;

    servo_pulse_sequencer_with_encoder u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;

    always #2 clk = ~clk;

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Decode the pulse pins from the shadow frame tick. Clamp each width to the
    // slot spacing so the windows never overlap.
    function automatic logic [PIN_BITS-1:0] pulse_pins();
        logic [PIN_BITS-1:0] pins;
        int                  lo;
        int                  span;
        int                  i;
        pins = '0;
        for (i = 0; i < CHANNELS; i++)
        begin
            lo   = FIRST_START + i * SLOT_SPACING;
            span = (pulse_width[i] > SLOT_SPACING) ? SLOT_SPACING : int'(pulse_width[i]);
            if (int'(frame_tick) >= lo && int'(frame_tick) < lo + span)
                pins[i] = 1'b1;
        end
        return pins;
    endfunction

    // Advance the shadow state by one event and return the result it causes.
    function automatic out_t apply_event(input in_t ev);
        out_t r;
        int   i;
        case (ev.action)
            ACT_TICK:
            begin
                // A count at or past the top (after the top was lowered) wraps too.
                if (frame_tick >= frame_top_set)
                    frame_tick = 16'd0;
                else
                    frame_tick = frame_tick + 16'd1;
            end
            ACT_START:
                rx_fill = 0;
            ACT_BYTE:
            begin
                // Drop bytes once the buffer is full, but still rebuild everything.
                if (rx_fill < BUFFER_BYTES)
                begin
                    rx_bytes[rx_fill] = ev.data_byte;
                    rx_fill++;
                end
                for (i = 0; i < PIN_BITS; i++)
                    pulse_width[i] = {rx_bytes[2 * i], rx_bytes[2 * i + 1]};
                edge_goal = {rx_bytes[TARGET_POS], rx_bytes[TARGET_POS + 1]};
                if (edge_goal != edge_total)
                    goal_hit = 1'b0;
            end
            default:
            begin
                edge_total = edge_total + 16'd1;
                if (edge_total == edge_goal)
                begin
                    goal_hit   = 1'b1;
                    edge_total = 16'd0;
                end
                else
                begin
                    goal_hit = 1'b0;
                end
            end
        endcase
        r.channel_pins   = pulse_pins();
        r.target_reached = goal_hit;
        r.encoder_count  = edge_total;
        return r;
    endfunction

    // Check each result transaction against the oldest prediction, predict each
    // input transaction, and run the watchdog.
    always @(posedge clk)
    begin : scoreboard
        out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_outputs.size() == 0)
                begin
                    $display("%0t: result with nothing predicted: %h", $time, out_data);
                    mismatches++;
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    if (out_data.channel_pins !== want.channel_pins)
                    begin
                        $display("%0t: channel_pins expected %b actual %b",
                                 $time, want.channel_pins, out_data.channel_pins);
                        mismatches++;
                    end
                    if (out_data.target_reached !== want.target_reached)
                    begin
                        $display("%0t: target_reached expected %b actual %b",
                                 $time, want.target_reached, out_data.target_reached);
                        mismatches++;
                    end
                    if (out_data.encoder_count !== want.encoder_count)
                    begin
                        $display("%0t: encoder_count expected %0d actual %0d",
                                 $time, want.encoder_count, out_data.encoder_count);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                predicted_outputs.push_back(apply_event(in_data));
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles = quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("tb_servo_pulse_sequencer_with_encoder failed");
                    $finish;
                end
            end
        end
    end

    // Drive out_ready at falling edges: hold off for a forced stretch when one
    // is requested, otherwise idle at random while idling is on.
    initial
    begin : receiver
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall_budget != 0)
            begin
                gap          = stall_budget;
                stall_budget = 0;
            end
            else
            begin
                gap = idle_on ? random_gap() : 0;
            end
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Offer one event and hold it until accepted. Enter and leave at a falling
    // edge; valid stays high on return so back-to-back transactions need no dip.
    task automatic send_event(input logic [1:0] act, input logic [7:0] data);
        int gap;
        gap = idle_on ? random_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= '{action: act, data_byte: data};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        events_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait for every predicted result to come back.
    task automatic settle();
        in_valid <= 1'b0;
        while (predicted_outputs.size() != 0)
            @(negedge clk);
    endtask

    // Write frame_top with the block idle, once every predicted result has come
    // back.
    task automatic write_frame_top(input logic [15:0] value);
        settle();
        repeat (3) @(negedge clk);
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we        <= 1'b0;
        frame_top_set = value;
    endtask

    // Send a full bus write: start, then seven big-endian widths and the target.
    task automatic send_frame(input width_arr_t widths, input logic [15:0] goal);
        int i;
        send_event(ACT_START, 8'($urandom));
        for (i = 0; i < PIN_BITS; i++)
        begin
            send_event(ACT_BYTE, widths[i][15:8]);
            send_event(ACT_BYTE, widths[i][7:0]);
        end
        send_event(ACT_BYTE, goal[15:8]);
        send_event(ACT_BYTE, goal[7:0]);
    endtask

    // Walk every event kind: zero width, widths at and past the slot spacing,
    // a byte past the full buffer, the target reached, and the flag dropped by
    // a later byte.
    task automatic test_directed_events();
        width_arr_t widths;
        idle_on = 1'b1;
        widths  = '{16'd0, 16'hFFFF, 16'd1, 16'd2782, 16'd2783, 16'h55AA, 16'd1500};
        send_event(ACT_TICK, 8'h00);
        send_event(ACT_EDGE, 8'hFF);
        send_frame(widths, 16'd2);
        send_event(ACT_BYTE, 8'hF8);
        send_event(ACT_EDGE, 8'h00);
        send_event(ACT_BYTE, 8'h12);
    endtask

    // Lower the top below the running count, then step through the wrap at a
    // top of one; end on the largest top.
    task automatic test_frame_wrap();
        repeat (4) send_event(ACT_TICK, 8'($urandom));
        write_frame_top(16'd1);
        repeat (3) send_event(ACT_TICK, 8'($urandom));
        write_frame_top(16'hFFFF);
        repeat (2) send_event(ACT_TICK, 8'($urandom));
    endtask

    // Tick from the frame start across the first channel window with a zero
    // width, then reprogram the widths at random inside the window so the
    // first pin can open and close mid-frame.
    task automatic test_pulse_sweep();
        width_arr_t widths;
        int         k;
        int         i;
        write_frame_top(FRAME_TOP_RESET);
        idle_on = 1'b1;
        widths  = '{16'd0, 16'hFFFF, 16'd1, 16'd2782, 16'd2783, 16'd1500, 16'd2100};
        send_frame(widths, 16'd3);
        for (k = 0; k < SWEEP_TICKS; k++)
        begin
            if (k == SWEEP_SWAP)
            begin
                for (i = 0; i < PIN_BITS; i++)
                    widths[i] = 16'($urandom_range(0, 3000));
                send_frame(widths, 16'($urandom_range(0, 8)));
            end
            send_event(ACT_TICK, 8'($urandom));
        end
    endtask

    // Hold the receiver off for a long stretch while the sender keeps offering,
    // so the result register fills and in_ready drops.
    task automatic test_backpressure();
        idle_on      = 1'b0;
        stall_budget = HOLD_OFF_LEN;
        repeat (60) send_event(2'($urandom), 8'($urandom));
        idle_on = 1'b1;
    endtask

    // Place the target a fixed run of edges ahead of the running count, wrapping
    // at 16 bits when the count is high, count up to it, then let a later byte
    // compare the cleared count against the target again.
    task automatic test_edge_wrap();
        width_arr_t  widths;
        logic [15:0] goal;
        idle_on = 1'b0;
        widths  = '{default: 16'd0};
        settle();
        goal = edge_total + 16'(EDGE_RUN);
        send_frame(widths, goal);
        repeat (EDGE_RUN) send_event(ACT_EDGE, 8'($urandom));
        send_event(ACT_START, 8'($urandom));
        send_event(ACT_BYTE, 8'h00);
        idle_on = 1'b1;
    endtask

    // Mixed traffic over several frame tops: tick and edge bursts, bus writes that
    // are mostly well-formed, with small targets and widths near the slot spacing,
    // some short or overlong writes, and some raw noise.
    task automatic test_random_traffic();
        int          phase;
        int          stop_at;
        int          roll;
        int          nbytes;
        int          k;
        logic [7:0]  data;
        logic [15:0] top;
        idle_on = 1'b1;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       top = 16'd1;
                1:       top = 16'd700;
                2:       top = 16'd3600;
                3:       top = 16'hFFFF;
                4:       top = 16'($urandom_range(1, 65535));
                default: top = FRAME_TOP_RESET;
            endcase
            write_frame_top(top);
            stop_at = events_sent + PHASE_EVENTS;
            while (events_sent < stop_at)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 35)
                begin
                    repeat ($urandom_range(1, 40)) send_event(ACT_TICK, 8'($urandom));
                end
                else if (roll < 60)
                begin
                    nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : BUFFER_BYTES;
                    send_event(ACT_START, 8'($urandom));
                    for (k = 0; k < nbytes; k++)
                    begin
                        data = 8'($urandom);
                        // Keep targets small so edge bursts can reach them, and
                        // push widths around the slot spacing.
                        if (k == TARGET_POS && $urandom_range(0, 3) != 0)
                            data = 8'd0;
                        else if (k == TARGET_POS + 1 && $urandom_range(0, 3) != 0)
                            data = 8'($urandom_range(0, 12));
                        else if (k < TARGET_POS && k % 2 == 0 && $urandom_range(0, 1) == 1)
                            data = 8'($urandom_range(0, 12));
                        send_event(ACT_BYTE, data);
                    end
                end
                else if (roll < 90)
                begin
                    repeat ($urandom_range(1, 12)) send_event(ACT_EDGE, 8'($urandom));
                end
                else
                begin
                    repeat ($urandom_range(1, 5)) send_event(2'($urandom), 8'($urandom));
                end
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_we        = 1'b0;
        cfg_data      = FRAME_TOP_RESET;
        idle_on       = 1'b0;
        stall_budget  = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        events_sent   = 0;

        // Shadow state starts from the reset values.
        frame_top_set = FRAME_TOP_RESET;
        frame_tick    = 16'd0;
        rx_bytes      = '{default: 8'd0};
        rx_fill       = 0;
        pulse_width   = WIDTH_RESET;
        edge_total    = 16'd0;
        edge_goal     = 16'd0;
        goal_hit      = 1'b0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_events();
        test_frame_wrap();
        test_pulse_sweep();
        test_backpressure();
        test_edge_wrap();
        test_random_traffic();

        // Drain, then let the clock run on so the pipeline has room to misbehave.
        settle();
        repeat (4) @(negedge clk);
        if (mismatches == 0)
            $display("tb_servo_pulse_sequencer_with_encoder passed");
        else
            $display("tb_servo_pulse_sequencer_with_encoder failed");
        $finish;
    end

endmodule
